@@ rtl/srm_pkg.sv @@
`default_nettype none

package srm_pkg;

    localparam int PLAYER_COUNT_DEF = 4;
    localparam int PLAYER_W         = 4;
    localparam int RANK_W           = 4;
    localparam int SCORE_W          = 32;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic [PLAYER_W-1:0]        player;
        logic signed [SCORE_W-1:0]  score_value;
    } req_t;

    typedef struct packed {
        logic [RANK_W-1:0]          rank;
        logic signed [SCORE_W-1:0]  margin;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_CALC,
        ST_ZERO
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic write;    // store score of incoming beat (datapath checks range)
        logic capture;  // latch queried player
        logic fetch;    // read queried player's score, restart scan
        logic scan;     // process one table entry
        logic calc;     // form rank and margin
        logic zero;     // out-of-range query result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_range;
        logic scan_last;
    } status_t;

    // a - b, saturated to signed 32 bits
    function automatic logic signed [SCORE_W-1:0] sat_sub(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] diff;
        begin
            diff = {a[SCORE_W-1], a} - {b[SCORE_W-1], b};
            if (diff[SCORE_W] != diff[SCORE_W-1])
            begin
                sat_sub = diff[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                        : {1'b0, {(SCORE_W-1){1'b1}}};
            end
            else
            begin
                sat_sub = diff[SCORE_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/srm_ctrl.sv @@
`default_nettype none

module srm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            req_type,
    input  wire srm_pkg::status_t status,
    output srm_pkg::cmd_t        cmd,
    output logic                 busy
);

    srm_pkg::state_t state_reg;
    srm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srm_pkg::ST_IDLE:
            begin
                if (start && req_type == srm_pkg::REQ_QUERY)
                begin
                    state_next = status.in_range ? srm_pkg::ST_FETCH : srm_pkg::ST_ZERO;
                end
            end
            srm_pkg::ST_FETCH: state_next = srm_pkg::ST_SCAN;
            srm_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = srm_pkg::ST_CALC;
                end
            end
            srm_pkg::ST_CALC:  state_next = srm_pkg::ST_IDLE;
            srm_pkg::ST_ZERO:  state_next = srm_pkg::ST_IDLE;
            default:           state_next = srm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            srm_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.write   = start && req_type == srm_pkg::REQ_WRITE;
                cmd.capture = start && req_type == srm_pkg::REQ_QUERY;
            end
            srm_pkg::ST_FETCH: cmd.fetch = 1'b1;
            srm_pkg::ST_SCAN:  cmd.scan  = 1'b1;
            srm_pkg::ST_CALC:  cmd.calc  = 1'b1;
            srm_pkg::ST_ZERO:  cmd.zero  = 1'b1;
            default:           busy      = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/srm_dp.sv @@
`default_nettype none

module srm_dp #(
    parameter int PLAYER_COUNT = srm_pkg::PLAYER_COUNT_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire srm_pkg::req_t    request,
    input  wire srm_pkg::cmd_t    cmd,
    output srm_pkg::status_t      status,
    output srm_pkg::result_t      result,
    output logic                  result_valid
);

    localparam int AW = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(PLAYER_COUNT - 1);

    logic signed [srm_pkg::SCORE_W-1:0] table_reg [PLAYER_COUNT];

    logic [AW-1:0]                      player_reg,  player_next;
    logic [AW-1:0]                      idx_reg,     idx_next;
    logic signed [srm_pkg::SCORE_W-1:0] own_reg,     own_next;
    logic signed [srm_pkg::SCORE_W-1:0] lead_reg,    lead_next;
    logic signed [srm_pkg::SCORE_W-1:0] second_reg,  second_next;
    logic [srm_pkg::RANK_W-1:0]         rank_reg,    rank_next;
    srm_pkg::result_t                   result_reg,  result_next;
    logic                               valid_reg,   valid_next;

    logic [AW-1:0]                      rd_addr;
    logic signed [srm_pkg::SCORE_W-1:0] rd_data;
    logic                               in_range;
    logic                               beats_own;
    logic [AW-1:0]                      wr_addr;

    assign in_range = {1'b0, request.player} < (srm_pkg::PLAYER_W + 1)'(PLAYER_COUNT);
    assign wr_addr  = request.player[AW-1:0];

    assign status.in_range  = in_range;
    assign status.scan_last = idx_reg == LAST_IDX;

    assign rd_addr = cmd.fetch ? player_reg : idx_reg;
    assign rd_data = table_reg[rd_addr];

    // entry ranks ahead of the queried player: higher score, or tie at lower index
    assign beats_own = (rd_data > own_reg) || (rd_data == own_reg && idx_reg < player_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAYER_COUNT; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (cmd.write && in_range)
        begin
            table_reg[wr_addr] <= request.score_value;
        end
    end

    always_comb
    begin
        player_next = player_reg;
        idx_next    = idx_reg;
        own_next    = own_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        rank_next   = rank_reg;
        result_next = result_reg;
        valid_next  = cmd.calc || cmd.zero;

        if (cmd.capture)
        begin
            player_next = wr_addr;
        end

        if (cmd.fetch)
        begin
            own_next  = rd_data;
            idx_next  = '0;
            rank_next = '0;
        end

        if (cmd.scan)
        begin
            idx_next = idx_reg + 1'b1;
            if (beats_own)
            begin
                rank_next = rank_reg + 1'b1;
            end
            // running max and runner-up, scanning upward so ties keep the lower index
            if (idx_reg == '0)
            begin
                lead_next = rd_data;
            end
            else if (rd_data > lead_reg)
            begin
                lead_next   = rd_data;
                second_next = lead_reg;
            end
            else if (idx_reg == AW'(1) || rd_data > second_reg)
            begin
                second_next = rd_data;
            end
        end

        if (cmd.calc)
        begin
            result_next.rank   = rank_reg;
            result_next.margin = (rank_reg == '0) ? srm_pkg::sat_sub(lead_reg, second_reg)
                                                  : srm_pkg::sat_sub(own_reg, lead_reg);
        end

        if (cmd.zero)
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        player_reg <= player_next;
        idx_reg    <= idx_next;
        own_reg    <= own_next;
        lead_reg   <= lead_next;
        second_reg <= second_next;
        rank_reg   <= rank_next;
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

@@ rtl/score_rank_margin.sv @@
// Score table with rank-and-margin query. Issue a beat by raising start while
// busy is low. A write (req_type 0) stores one signed Q16.16 score and never
// raises busy; writes to a player at or above PLAYER_COUNT are dropped. A
// query (req_type 1) holds busy while it reads the queried score, scans every
// table entry to find leader, runner-up and rank, and forms the saturated
// margin. The result then shows on result for exactly one cycle with
// result_valid high; the next beat may be accepted in that same cycle. The
// receiver cannot stall, so result must be taken when valid. A query of an
// out-of-range player answers rank 0, margin 0 without a scan. The table
// resets to all zero.
`default_nettype none

module score_rank_margin #(
    parameter int PLAYER_COUNT = srm_pkg::PLAYER_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire srm_pkg::req_t   request,
    output logic                 busy,
    output srm_pkg::result_t     result,
    output logic                 result_valid
);

    srm_pkg::cmd_t    cmd;
    srm_pkg::status_t status;

    srm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    srm_dp #(
        .PLAYER_COUNT (PLAYER_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef NO_ASSERTIONS
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without a query in flight");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type == srm_pkg::REQ_WRITE) |=> !busy)
        else $error("write beat raised busy");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type == srm_pkg::REQ_QUERY) |=> busy)
        else $error("query beat did not raise busy");

    a_oor_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type == srm_pkg::REQ_QUERY && !status.in_range)
        |=> ##1 (result_valid && result.rank == '0 && result.margin == '0))
        else $error("out-of-range query result wrong or late");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import srm_pkg::*;

    localparam int NUM_PLAYERS  = PLAYER_COUNT_DEF;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT   = 200;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    typedef struct packed {
        req_t    beat;
        logic    typed;   // want holds a hand-written answer
        result_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    req_t      request = '0;
    logic      busy;
    result_t   result;
    logic      result_valid;

    // travel with the beat so the monitor knows what to expect
    logic      beat_typed = 1'b0;
    result_t   beat_want = '0;

    logic signed [SCORE_W-1:0] score_book [NUM_PLAYERS];
    logic signed [SCORE_W-1:0] drawn_scores [NUM_PLAYERS];
    result_t   standing_q [$];
    stim_row_t directed [$];
    int        error_count = 0;
    int        idle_cycles = 0;

    score_rank_margin i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic bit ranks_ahead(input int unsigned a, input int unsigned b);
        if (score_book[a] != score_book[b])
        begin
            return score_book[a] > score_book[b];
        end
        return a < b;
    endfunction

    // Applies one beat to the score book; returns 1 with the standing when
    // the beat produces a result.
    function automatic bit predict_standing(input req_t beat, output result_t res);
        int unsigned p;
        int unsigned place;
        int unsigned lead_idx;
        int unsigned second_idx;
        longint      diff;
        res = '0;
        p = beat.player;
        if (beat.req_type == REQ_WRITE)
        begin
            if (p < NUM_PLAYERS)
            begin
                score_book[p] = beat.score_value;
            end
            return 1'b0;
        end
        if (p >= NUM_PLAYERS)
        begin
            return 1'b1;
        end
        place = 0;
        lead_idx = 0;
        for (int unsigned j = 0; j < NUM_PLAYERS; j++)
        begin
            if (j != p && ranks_ahead(j, p))
            begin
                place++;
            end
            if (ranks_ahead(j, lead_idx))
            begin
                lead_idx = j;
            end
        end
        if (place == 0)
        begin
            second_idx = (lead_idx == 0) ? 1 : 0;
            for (int unsigned j = 0; j < NUM_PLAYERS; j++)
            begin
                if (j != lead_idx && ranks_ahead(j, second_idx))
                begin
                    second_idx = j;
                end
            end
            diff = longint'(score_book[lead_idx]) - longint'(score_book[second_idx]);
        end
        else
        begin
            diff = longint'(score_book[p]) - longint'(score_book[lead_idx]);
        end
        if (diff > longint'(SCORE_MAX))
        begin
            diff = longint'(SCORE_MAX);
        end
        else if (diff < longint'(SCORE_MIN))
        begin
            diff = longint'(SCORE_MIN);
        end
        res.rank = place[RANK_W-1:0];
        res.margin = diff[SCORE_W-1:0];
        return 1'b1;
    endfunction

    function automatic stim_row_t make_row(
        input logic                      req,
        input logic [PLAYER_W-1:0]       who,
        input logic signed [SCORE_W-1:0] score,
        input logic                      typed,
        input logic [RANK_W-1:0]         rk,
        input logic signed [SCORE_W-1:0] mg
    );
        stim_row_t r;
        r.beat.req_type    = req;
        r.beat.player      = who;
        r.beat.score_value = score;
        r.typed            = typed;
        r.want.rank        = rk;
        r.want.margin      = mg;
        return r;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        logic signed [SCORE_W-1:0] score;
        r = '0;
        r.beat.req_type = ($urandom_range(0, 1) == 1) ? REQ_QUERY : REQ_WRITE;
        if ($urandom_range(0, 99) < 85)
        begin
            r.beat.player = PLAYER_W'($urandom_range(0, NUM_PLAYERS - 1));
        end
        else
        begin
            r.beat.player = PLAYER_W'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 9))
            0: score = SCORE_MAX;
            1: score = SCORE_MIN;
            // reuse a score already handed out to force ties
            2, 3: score = drawn_scores[$urandom_range(0, NUM_PLAYERS - 1)];
            4, 5: score = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: score = $urandom;
        endcase
        r.beat.score_value = score;
        if (r.beat.req_type == REQ_WRITE && r.beat.player < NUM_PLAYERS)
        begin
            drawn_scores[r.beat.player] = score;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : port_monitor
        result_t want;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                moved = 1'b1;
                if (predict_standing(request, want))
                begin
                    if (beat_typed)
                    begin
                        want = beat_want;
                    end
                    standing_q.push_back(want);
                end
            end
            if (result_valid)
            begin
                moved = 1'b1;
                if (standing_q.size() == 0)
                begin
                    flag_mismatch($sformatf("result rank %0d margin %h with nothing expected",
                                            result.rank, result.margin));
                end
                else
                begin
                    want = standing_q.pop_front();
                    if (result.rank !== want.rank)
                    begin
                        flag_mismatch($sformatf("rank %0d, expected %0d",
                                                result.rank, want.rank));
                    end
                    if (result.margin !== want.margin)
                    begin
                        flag_mismatch($sformatf("margin %h, expected %h",
                                                result.margin, want.margin));
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int        n_sent;
        int        total;
        int        burst;
        int        gap;
        stim_row_t cur;

        for (int i = 0; i < NUM_PLAYERS; i++)
        begin
            score_book[i] = '0;
            drawn_scores[i] = '0;
        end

        // fresh table: everyone ties at zero
        directed.push_back(make_row(REQ_QUERY, 0, 32'sh5555_5555, 1, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 3, 0, 1, 3, 0));
        // out-of-range player answers zero
        directed.push_back(make_row(REQ_QUERY, 4, 0, 1, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 15, SCORE_MIN, 1, 0, 0));
        directed.push_back(make_row(REQ_WRITE, 0, SCORE_MAX, 0, 0, 0));
        directed.push_back(make_row(REQ_WRITE, 1, SCORE_MIN, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 0, 0, 1, 0, SCORE_MAX));
        // MIN - MAX saturates
        directed.push_back(make_row(REQ_QUERY, 1, 0, 1, 3, SCORE_MIN));
        directed.push_back(make_row(REQ_QUERY, 2, 0, 1, 1, 32'sh8000_0001));
        // dropped write
        directed.push_back(make_row(REQ_WRITE, 15, 32'sh1234_5678, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 15, 0, 1, 0, 0));
        // leader ties runner-up
        directed.push_back(make_row(REQ_WRITE, 2, SCORE_MAX, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 0, 0, 1, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 2, 0, 1, 1, 0));
        directed.push_back(make_row(REQ_WRITE, 3, SCORE_MAX, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 3, 0, 1, 2, 0));
        directed.push_back(make_row(REQ_QUERY, 1, 0, 1, 3, SCORE_MIN));
        // fractional scores
        directed.push_back(make_row(REQ_WRITE, 0, 32'sh0001_8000, 0, 0, 0));
        directed.push_back(make_row(REQ_WRITE, 1, 32'shFFFF_8000, 0, 0, 0));
        directed.push_back(make_row(REQ_WRITE, 2, 32'sh0001_0000, 0, 0, 0));
        directed.push_back(make_row(REQ_WRITE, 3, 32'shFFFF_FFFF, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 0, 0, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 1, 0, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 2, 0, 0, 0, 0));
        directed.push_back(make_row(REQ_QUERY, 3, 0, 0, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        n_sent = 0;
        total = directed.size() + RANDOM_ITEMS;
        while (n_sent < total)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n_sent < total)
            begin
                cur = (n_sent < directed.size()) ? directed[n_sent] : random_row();
                start      <= 1'b1;
                request    <= cur.beat;
                beat_typed <= cur.typed;
                beat_want  <= cur.want;
                @(posedge clk);
                while (busy)
                begin
                    @(posedge clk);
                end
                n_sent++;
                burst--;
            end
            // gap of zero keeps start high into the next burst
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        while (standing_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (NUM_PLAYERS + 8) @(posedge clk);

        if (error_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
